// ===== rtl/swrl_pkg.sv =====
// Shared types, widths and codes of the sliding window rate limiter.
// Used by every module of the block; depends on nothing.
package swrl_pkg;

  localparam int NUM_KEYS_DEF      = 64;
  localparam int SLOTS_PER_KEY_DEF = 16;

  localparam int CMD_W       = 3;
  localparam int KEY_W       = 6;
  localparam int TIME_W      = 48;
  localparam int LIM_W       = 5;
  localparam int WIN_W       = 12;
  localparam int REM_W       = 5;
  localparam int RETRY_W     = 12;
  localparam int WIN_MS_W    = 22;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int unsigned MS_PER_S       = 1000;
  localparam int unsigned BURST_SPAN_MS  = 1000;
  localparam logic [RETRY_W-1:0] RETRY_CAP = 12'd4095;
  // A wait of this many ms or more saturates the answer.
  localparam int unsigned RETRY_SAT_DIFF = 4094000;
  localparam int DIV_W = 22;

  localparam logic [LIM_W-1:0] MAX_REQ_RST = 5'd16;
  localparam logic [LIM_W-1:0] BURST_RST   = 5'd0;
  localparam logic [WIN_W-1:0] WIN_RST     = 12'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_REQUESTS   = 2'd0,
    REG_BURST_MAX      = 2'd1,
    REG_WINDOW_SECONDS = 2'd2
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOW     = 3'd0,
    CMD_REMAINING = 3'd1,
    CMD_RETRY     = 3'd2,
    CMD_RESET_KEY = 3'd3,
    CMD_RESET_ALL = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_PURGE_RD,
    ST_PURGE_CHK,
    ST_DECIDE,
    ST_BURST_RD,
    ST_BURST_CHK,
    ST_DIV,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RETRY_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/swrl_div.sv =====
// Divider by 1000 for the retry answer, built as a multiply by the reciprocal.
// Depends on swrl_pkg.
module swrl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  swrl_pkg::div_req_t req,
  output swrl_pkg::div_rsp_t rsp
);

  // The reciprocal is 2^32 / 1000 rounded up. It gives the exact floor for every
  // dividend below 2^22.
  localparam int               RECIP_SHIFT = 32;
  localparam int               RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP     = 23'd4294968;
  localparam int               PROD_W      = swrl_pkg::DIV_W + RECIP_W;

  logic                       go_r, go_nxt;
  logic                       done_r, done_nxt;
  logic [swrl_pkg::DIV_W-1:0] dvd_r, dvd_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;

  // The dividend is registered first, so the multiply starts from a flop.
  always_comb begin
    go_nxt   = req.start;
    done_nxt = go_r;
    dvd_nxt  = req.start ? req.dividend : dvd_r;
    prod_nxt = PROD_W'(dvd_r * RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      go_r   <= go_nxt;
      done_r <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    prod_r <= prod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = prod_r[RECIP_SHIFT +: swrl_pkg::RETRY_W];

endmodule

// ===== rtl/swrl_engine.sv =====
// Command sequencer with the per-key ring metadata memory and the stamp memory.
// Depends on swrl_pkg; drives the swrl_div divider through a request struct.
module swrl_engine #(
  parameter int NUM_KEYS      = swrl_pkg::NUM_KEYS_DEF,
  parameter int SLOTS_PER_KEY = swrl_pkg::SLOTS_PER_KEY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [swrl_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [swrl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic [swrl_pkg::LIM_W-1:0]          max_req,
  input  logic [swrl_pkg::LIM_W-1:0]          burst_lim,
  input  logic [swrl_pkg::WIN_MS_W-1:0]       win_ms,
  output swrl_pkg::div_req_t                  div_req,
  input  swrl_pkg::div_rsp_t                  div_rsp
);

  localparam int HW    = (SLOTS_PER_KEY > 1) ? $clog2(SLOTS_PER_KEY) : 1;
  localparam int CW    = $clog2(SLOTS_PER_KEY + 1);
  localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int DEPTH = NUM_KEYS * SLOTS_PER_KEY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = swrl_pkg::TIME_W;

  function automatic logic [HW-1:0] slot_add(input logic [HW-1:0] head,
                                             input logic [CW-1:0] pos);
    int s;
    s = int'(head) + int'(pos);
    if (s >= SLOTS_PER_KEY) s = s - SLOTS_PER_KEY;
    return HW'(s);
  endfunction

  function automatic logic [AW-1:0] stamp_addr(input logic [KW-1:0] key,
                                               input logic [HW-1:0] slot);
    return AW'(int'(key) * SLOTS_PER_KEY + int'(slot));
  endfunction

  // Memories: ring head and count per key, and the stored request times.
  logic [HW+CW-1:0] meta_mem [NUM_KEYS];
  logic [TW-1:0]    stamp_mem [DEPTH];
  logic [HW+CW-1:0] meta_q;
  logic [TW-1:0]    stamp_q;

  logic             meta_re, meta_we;
  logic [KW-1:0]    meta_raddr, meta_waddr;
  logic [HW+CW-1:0] meta_wdata;
  logic             stamp_re, stamp_we;
  logic [AW-1:0]    stamp_raddr, stamp_waddr;

  swrl_pkg::state_t state_r, state_nxt;
  swrl_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [TW-1:0]    now_r, now_nxt;
  logic [HW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    recent_r, recent_nxt;
  logic             ok_r, ok_nxt;
  logic             all_r, all_nxt;
  logic [KW-1:0]    clr_r, clr_nxt;
  logic             allowed_r, allowed_nxt;
  logic [swrl_pkg::REM_W-1:0]   remaining_r, remaining_nxt;
  logic [swrl_pkg::RETRY_W-1:0] retry_r, retry_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [swrl_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                     in_xfer, out_free;
  swrl_pkg::cmd_t           in_cmd;
  logic [swrl_pkg::KEY_W-1:0] in_key;
  logic                     in_cmd_known, in_key_ok;
  logic [CW-1:0]            limit;
  logic [TW:0]              stamp_ext, now_ext, expires, diff;
  logic                     stale, recent_hit, in_future, saturate;
  logic                     under_limit, retry_due, burst_on, clr_last;

  assign in_tready = (state_r == swrl_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_cmd    = swrl_pkg::cmd_t'(in_tdata[2:0]);
  assign in_key    = in_tdata[8:3];
  assign in_key_ok = (32'(in_key) < NUM_KEYS);
  assign in_cmd_known = (in_tdata[2:0] <= 3'(swrl_pkg::CMD_RESET_ALL));

  assign limit = (32'(max_req) > SLOTS_PER_KEY) ? CW'(SLOTS_PER_KEY) : CW'(max_req);

  assign stamp_ext  = {1'b0, stamp_q};
  assign now_ext    = {1'b0, now_r};
  assign expires    = stamp_ext + (TW+1)'(win_ms);
  assign diff       = expires - now_ext;
  assign stale      = expires < now_ext;
  assign recent_hit = (stamp_ext + (TW+1)'(swrl_pkg::BURST_SPAN_MS)) >= now_ext;
  assign in_future  = expires > now_ext;
  assign saturate   = diff >= (TW+1)'(swrl_pkg::RETRY_SAT_DIFF);
  assign under_limit = count_r < limit;
  assign retry_due  = (count_r != '0) && (count_r >= limit) && in_future;
  assign burst_on   = (burst_lim != '0);
  assign clr_last   = (32'(clr_r) == NUM_KEYS - 1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrl_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = all_r ? swrl_pkg::ST_RESULT : swrl_pkg::ST_IDLE;
      end
      swrl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == swrl_pkg::CMD_RESET_ALL) state_nxt = swrl_pkg::ST_CLEAR;
          else if (!in_cmd_known || !in_key_ok) state_nxt = swrl_pkg::ST_RESULT;
          else state_nxt = swrl_pkg::ST_META;
        end
      end
      swrl_pkg::ST_META: state_nxt = swrl_pkg::ST_PURGE_RD;
      swrl_pkg::ST_PURGE_RD: begin
        state_nxt = (count_r == '0) ? swrl_pkg::ST_DECIDE : swrl_pkg::ST_PURGE_CHK;
      end
      swrl_pkg::ST_PURGE_CHK: begin
        state_nxt = stale ? swrl_pkg::ST_PURGE_RD : swrl_pkg::ST_DECIDE;
      end
      swrl_pkg::ST_DECIDE: begin
        state_nxt = swrl_pkg::ST_COMMIT;
        if (cmd_r == swrl_pkg::CMD_ALLOW && under_limit && burst_on)
          state_nxt = swrl_pkg::ST_BURST_RD;
        if (cmd_r == swrl_pkg::CMD_RETRY && retry_due && !saturate)
          state_nxt = swrl_pkg::ST_DIV;
      end
      swrl_pkg::ST_BURST_RD: begin
        state_nxt = (idx_r == '0) ? swrl_pkg::ST_COMMIT : swrl_pkg::ST_BURST_CHK;
      end
      swrl_pkg::ST_BURST_CHK: begin
        state_nxt = recent_hit ? swrl_pkg::ST_BURST_RD : swrl_pkg::ST_COMMIT;
      end
      swrl_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = swrl_pkg::ST_COMMIT;
      end
      swrl_pkg::ST_COMMIT: state_nxt = swrl_pkg::ST_RESULT;
      swrl_pkg::ST_RESULT: begin
        if (out_free) state_nxt = swrl_pkg::ST_IDLE;
      end
      default: state_nxt = swrl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    recent_nxt    = recent_r;
    ok_nxt        = ok_r;
    all_nxt       = all_r;
    clr_nxt       = clr_r;
    allowed_nxt   = allowed_r;
    remaining_nxt = remaining_r;
    retry_nxt     = retry_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    meta_re       = 1'b0;
    meta_raddr    = key_r;
    meta_we       = 1'b0;
    meta_waddr    = key_r;
    meta_wdata    = {head_r, count_r};
    stamp_re      = 1'b0;
    stamp_raddr   = stamp_addr(key_r, head_r);
    stamp_we      = 1'b0;
    stamp_waddr   = stamp_addr(key_r, slot_add(head_r, count_r));
    div_req.start    = 1'b0;
    div_req.dividend = diff[swrl_pkg::DIV_W-1:0];
    case (state_r)
      swrl_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = KW'(clr_r + 1'b1);
      end
      swrl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt       = in_cmd;
          key_nxt       = KW'(in_key);
          now_nxt       = in_tdata[56:9];
          allowed_nxt   = 1'b0;
          remaining_nxt = '0;
          retry_nxt     = '0;
          ok_nxt        = 1'b0;
          all_nxt       = (in_cmd == swrl_pkg::CMD_RESET_ALL);
          clr_nxt       = '0;
          meta_re       = 1'b1;
          meta_raddr    = KW'(in_key);
        end
      end
      swrl_pkg::ST_META: begin
        head_nxt  = meta_q[HW+CW-1:CW];
        count_nxt = meta_q[CW-1:0];
      end
      swrl_pkg::ST_PURGE_RD: begin
        stamp_re = (count_r != '0);
      end
      swrl_pkg::ST_PURGE_CHK: begin
        if (stale) begin
          head_nxt  = slot_add(head_r, CW'(1));
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      swrl_pkg::ST_DECIDE: begin
        case (cmd_r)
          swrl_pkg::CMD_ALLOW: begin
            ok_nxt     = under_limit;
            idx_nxt    = count_r;
            recent_nxt = '0;
          end
          swrl_pkg::CMD_REMAINING: begin
            remaining_nxt = under_limit ? swrl_pkg::REM_W'(limit - count_r) : '0;
          end
          swrl_pkg::CMD_RETRY: begin
            if (retry_due && saturate) retry_nxt = swrl_pkg::RETRY_CAP;
            div_req.start = retry_due && !saturate;
          end
          swrl_pkg::CMD_RESET_KEY: begin
            head_nxt  = '0;
            count_nxt = '0;
          end
          default: ;
        endcase
      end
      swrl_pkg::ST_BURST_RD: begin
        // Walk back from the newest time; stop at the first one outside 1000 ms.
        if (idx_r == '0) begin
          ok_nxt = (32'(recent_r) < 32'(burst_lim));
        end else begin
          stamp_re    = 1'b1;
          stamp_raddr = stamp_addr(key_r, slot_add(head_r, CW'(idx_r - 1'b1)));
        end
      end
      swrl_pkg::ST_BURST_CHK: begin
        if (recent_hit) begin
          recent_nxt = CW'(recent_r + 1'b1);
          idx_nxt    = CW'(idx_r - 1'b1);
        end else begin
          ok_nxt = (32'(recent_r) < 32'(burst_lim));
        end
      end
      swrl_pkg::ST_DIV: begin
        if (div_rsp.done) retry_nxt = swrl_pkg::RETRY_W'(div_rsp.quot + 1'b1);
      end
      swrl_pkg::ST_COMMIT: begin
        meta_we = 1'b1;
        if (cmd_r == swrl_pkg::CMD_ALLOW && ok_r) begin
          stamp_we    = 1'b1;
          count_nxt   = CW'(count_r + 1'b1);
          meta_wdata  = {head_r, CW'(count_r + 1'b1)};
          allowed_nxt = 1'b1;
        end
      end
      swrl_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, retry_r, remaining_r, allowed_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (meta_re) meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[stamp_waddr] <= now_r;
    if (stamp_re) stamp_q <= stamp_mem[stamp_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrl_pkg::ST_CLEAR;
      clr_r       <= '0;
      all_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      all_r       <= all_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    now_r       <= now_nxt;
    head_r      <= head_nxt;
    count_r     <= count_nxt;
    idx_r       <= idx_nxt;
    recent_r    <= recent_nxt;
    ok_r        <= ok_nxt;
    allowed_r   <= allowed_nxt;
    remaining_r <= remaining_nxt;
    retry_r     <= retry_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/sliding_window_rate_limiter.sv =====
// Sliding window rate limiter: configuration registers, command engine and
// retry divider. Depends on swrl_pkg, swrl_engine and swrl_div.
//
// Usage: each transfer on the in_ channel carries a command (allow, remaining,
// retry_after, reset key, reset all), a key index and a millisecond time that
// never decreases. Every command returns exactly one transfer on the out_
// channel. The cfg_ channel is always ready; the user must write registers
// only while no command is in flight, which the block does not enforce.
//
// Timing: one command at a time. A command reads its key's metadata, purges
// expired times, scans recent times for the burst check of an allow, and for
// a retry_after answer that needs it runs the divide by 1000. Reset all sweeps
// the key metadata memory. The walk through the stamp memory, one read per
// step, sets how long a command takes.
//
// Reset: a clearing pass writes every key's ring to empty, and in_tready
// stays low until it ends. The result sits in an output register,
// so in_tready returns while out_tvalid waits for out_tready; a second result
// waits inside the engine until that register frees up.
module sliding_window_rate_limiter #(
  parameter int NUM_KEYS      = swrl_pkg::NUM_KEYS_DEF,
  parameter int SLOTS_PER_KEY = swrl_pkg::SLOTS_PER_KEY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command [2:0], key_index [8:3], now_ms [56:9], zero [63:57]
  input  logic [swrl_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // allowed [0], remaining [5:1], retry_seconds [17:6], zero [23:18]
  output logic [swrl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [swrl_pkg::LIM_W-1:0]    max_req_r, max_req_nxt;
  logic [swrl_pkg::LIM_W-1:0]    burst_r, burst_nxt;
  logic [swrl_pkg::WIN_W-1:0]    win_r, win_nxt;
  logic [swrl_pkg::WIN_MS_W-1:0] win_ms_r, win_ms_nxt;
  swrl_pkg::div_req_t            div_req;
  swrl_pkg::div_rsp_t            div_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    max_req_nxt = max_req_r;
    burst_nxt   = burst_r;
    win_nxt     = win_r;
    if (cfg_valid) begin
      case (swrl_pkg::reg_idx_t'(cfg_index))
        swrl_pkg::REG_MAX_REQUESTS:   max_req_nxt = cfg_data[swrl_pkg::LIM_W-1:0];
        swrl_pkg::REG_BURST_MAX:      burst_nxt   = cfg_data[swrl_pkg::LIM_W-1:0];
        swrl_pkg::REG_WINDOW_SECONDS: win_nxt     = cfg_data;
        default: ;
      endcase
    end
    win_ms_nxt = swrl_pkg::WIN_MS_W'(win_r * 10'(swrl_pkg::MS_PER_S));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= swrl_pkg::MAX_REQ_RST;
      burst_r   <= swrl_pkg::BURST_RST;
      win_r     <= swrl_pkg::WIN_RST;
      win_ms_r  <= swrl_pkg::WIN_MS_W'(swrl_pkg::WIN_RST * 10'(swrl_pkg::MS_PER_S));
    end else begin
      max_req_r <= max_req_nxt;
      burst_r   <= burst_nxt;
      win_r     <= win_nxt;
      win_ms_r  <= win_ms_nxt;
    end
  end

  swrl_engine #(
    .NUM_KEYS      (NUM_KEYS),
    .SLOTS_PER_KEY (SLOTS_PER_KEY)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .max_req    (max_req_r),
    .burst_lim  (burst_r),
    .win_ms     (win_ms_r),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

  swrl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== rtl/swrl_checker.sv =====
// Port-level checks of the rate limiter, bound to the top level.
// Depends on swrl_pkg and sliding_window_rate_limiter.
module swrl_checker #(
  parameter int SLOTS_PER_KEY = swrl_pkg::SLOTS_PER_KEY_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [swrl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Commands are taken one at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken back to back");

  // At most one answer field is filled for any command.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones({out_tdata[0], out_tdata[5:1] != 5'd0,
                               out_tdata[17:6] != 12'd0}) <= 1)
    else $error("more than one answer field set");

  // Remaining quota never exceeds the ring size, and padding stays zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[5:1]) <= SLOTS_PER_KEY) && (out_tdata[23:18] == 6'd0))
    else $error("remaining out of range or padding set");

endmodule

bind sliding_window_rate_limiter swrl_checker #(
  .SLOTS_PER_KEY (SLOTS_PER_KEY)
) u_swrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
